[src/edf_ring_scheduler_core_macros.svh]
// assertion helpers shared by the scheduler core files
`ifndef EDF_RING_SCHEDULER_CORE_MACROS_SVH
`define EDF_RING_SCHEDULER_CORE_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked out of reset
`define EDFRS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define EDFRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define EDFRS_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define EDFRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[src/edfrs_pkg.sv]
`default_nettype none

package edfrs_pkg;

  // request payload
  typedef struct packed {
    logic       kind;
    logic [7:0] task_id;
    logic [14:0] deadline;
    logic [7:0] priority_req;
  } in_t;

  // result payload
  typedef struct packed {
    logic       done_res;
    logic [7:0] dispatched_id;
    logic [2:0] queued;
  } out_t;

  // one ring slot as stored in the entry ram
  typedef struct packed {
    logic [7:0]         id;
    logic signed [15:0] countdown;
    logic [7:0]         rank;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam logic signed [15:0] CD_MIN = 16'sh8000;

  // request kinds
  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_SWAP_HEAD,
    ST_SWAP_BEST,
    ST_RETIRE,
    ST_DEC,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic capture;
    logic add_write;
    logic scan_step;
    logic swap_head;
    logic swap_best;
    logic retire;
    logic dec_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_tick;
    logic empty;
    logic scan_done;
    logic need_swap;
    logic dec_done;
    logic out_free;
  } ctrl_stat_t;

endpackage

`default_nettype wire

[src/edfrs_ram.sv]
`default_nettype none

module edfrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/edfrs_ctrl.sv]
`default_nettype none
`include "edf_ring_scheduler_core_macros.svh"

module edfrs_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire edfrs_pkg::ctrl_stat_t stat,
  output logic                      in_ready,
  output edfrs_pkg::ctrl_cmd_t      cmd
);

  edfrs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= edfrs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      edfrs_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (!stat.in_tick) begin
            state_next = edfrs_pkg::ST_ADD;
          end else if (stat.empty) begin
            state_next = edfrs_pkg::ST_RESULT;
          end else begin
            state_next = edfrs_pkg::ST_SCAN;
          end
        end
      end
      edfrs_pkg::ST_ADD: state_next = edfrs_pkg::ST_RESULT;
      edfrs_pkg::ST_SCAN: begin
        if (stat.scan_done) begin
          state_next = stat.need_swap ? edfrs_pkg::ST_SWAP_HEAD : edfrs_pkg::ST_RETIRE;
        end
      end
      edfrs_pkg::ST_SWAP_HEAD: state_next = edfrs_pkg::ST_SWAP_BEST;
      edfrs_pkg::ST_SWAP_BEST: state_next = edfrs_pkg::ST_RETIRE;
      edfrs_pkg::ST_RETIRE:    state_next = edfrs_pkg::ST_DEC;
      edfrs_pkg::ST_DEC: begin
        if (stat.dec_done) begin
          state_next = edfrs_pkg::ST_RESULT;
        end
      end
      edfrs_pkg::ST_RESULT: begin
        if (stat.out_free) begin
          state_next = edfrs_pkg::ST_IDLE;
        end
      end
      default: state_next = edfrs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    case (state)
      edfrs_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      edfrs_pkg::ST_ADD:       cmd.add_write = 1'b1;
      edfrs_pkg::ST_SCAN:      cmd.scan_step = 1'b1;
      edfrs_pkg::ST_SWAP_HEAD: cmd.swap_head = 1'b1;
      edfrs_pkg::ST_SWAP_BEST: cmd.swap_best = 1'b1;
      edfrs_pkg::ST_RETIRE:    cmd.retire    = 1'b1;
      edfrs_pkg::ST_DEC:       cmd.dec_step  = 1'b1;
      edfrs_pkg::ST_RESULT:    cmd.load_out  = stat.out_free;
      default: cmd = '0;
    endcase
  end

  `EDFRS_ASSERT_NEXT(a_scan_holds, clk, rst, state == edfrs_pkg::ST_SCAN && !stat.scan_done, state == edfrs_pkg::ST_SCAN, "scan left before the last entry")
  `EDFRS_ASSERT_NEXT(a_result_to_idle, clk, rst, state == edfrs_pkg::ST_RESULT && stat.out_free, state == edfrs_pkg::ST_IDLE, "result posted but controller not idle")
  `EDFRS_ASSERT_NEXT(a_empty_tick, clk, rst, cmd.capture && stat.in_tick && stat.empty, state == edfrs_pkg::ST_RESULT, "tick on empty ring did not go straight to result")

endmodule

`default_nettype wire

[src/edfrs_datapath.sv]
`default_nettype none
`include "edf_ring_scheduler_core_macros.svh"

module edfrs_datapath #(
  parameter int RING_SLOTS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire edfrs_pkg::in_t        in_data,
  input  wire edfrs_pkg::ctrl_cmd_t  cmd,
  input  wire logic                  out_ready,
  output edfrs_pkg::ctrl_stat_t      stat,
  output logic                       out_valid,
  output edfrs_pkg::out_t            out_data
);

  localparam int PW = $clog2(RING_SLOTS);
  localparam int CW = PW + 3;
  localparam logic [PW-1:0] LAST_SLOT = PW'(RING_SLOTS - 1);
  localparam logic [CW-1:0] SLOTS_C   = CW'(RING_SLOTS);

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] i);
    next_slot = (i == LAST_SLOT) ? '0 : i + 1'b1;
  endfunction

  logic [PW-1:0] head, tail;
  logic [PW-1:0] scan_addr, pend_addr, best_idx;
  logic          pend;
  logic          issue;
  logic          full;
  logic          best_hit;
  logic          done_q;
  logic [7:0]    disp_q;
  edfrs_pkg::in_t    req;
  edfrs_pkg::entry_t best_entry, head_entry, rd_entry, dec_entry;
  logic [edfrs_pkg::ENTRY_W-1:0] rd_data;
  logic [CW-1:0] count;

  // entry ram ports
  logic                          we;
  logic [PW-1:0]                 waddr;
  edfrs_pkg::entry_t             wentry;

  edfrs_ram #(
    .WIDTH(edfrs_pkg::ENTRY_W),
    .DEPTH(RING_SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wentry),
    .raddr(scan_addr),
    .rdata(rd_data)
  );

  assign rd_entry = edfrs_pkg::entry_t'(rd_data);
  assign full     = (next_slot(tail) == head);
  assign issue    = (scan_addr != tail);

  // later entry takes over on a smaller countdown, or on a tie with a larger rank
  assign best_hit = (rd_entry.countdown < best_entry.countdown) ||
                    ((rd_entry.countdown == best_entry.countdown) &&
                     (best_entry.rank < rd_entry.rank));

  always_comb begin
    dec_entry = rd_entry;
    if (rd_entry.countdown != edfrs_pkg::CD_MIN) begin
      dec_entry.countdown = rd_entry.countdown - 16'sd1;
    end
  end

  always_comb begin
    we     = 1'b0;
    waddr  = tail;
    wentry = best_entry;
    if (cmd.add_write) begin
      we                = !full;
      waddr             = tail;
      wentry.id         = req.task_id;
      wentry.countdown  = {1'b0, req.deadline};
      wentry.rank       = req.priority_req;
    end else if (cmd.swap_head) begin
      we     = 1'b1;
      waddr  = head;
      wentry = best_entry;
    end else if (cmd.swap_best) begin
      we     = 1'b1;
      waddr  = best_idx;
      wentry = head_entry;
    end else if (cmd.dec_step) begin
      we     = pend;
      waddr  = pend_addr;
      wentry = dec_entry;
    end
  end

  always_comb begin
    if (tail >= head) begin
      count = CW'(tail) - CW'(head);
    end else begin
      count = CW'(tail) + SLOTS_C - CW'(head);
    end
  end

  assign stat.in_tick   = (in_data.kind == edfrs_pkg::KIND_TICK);
  assign stat.empty     = (head == tail);
  assign stat.scan_done = !pend && !issue;
  assign stat.dec_done  = !pend && !issue;
  assign stat.need_swap = (best_idx != head);
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      scan_addr <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.capture) begin
        scan_addr <= head;
        pend      <= 1'b0;
      end else if (cmd.scan_step || cmd.dec_step) begin
        pend <= issue;
        if (issue) begin
          scan_addr <= next_slot(scan_addr);
        end
      end else if (cmd.retire) begin
        pend <= 1'b0;
        if (best_entry.countdown <= 16'sd0) begin
          head      <= next_slot(head);
          scan_addr <= next_slot(head);
        end else begin
          scan_addr <= head;
        end
      end
      if (cmd.add_write && !full) begin
        tail <= next_slot(tail);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req    <= in_data;
      done_q <= 1'b0;
      disp_q <= '0;
    end
    if ((cmd.scan_step || cmd.dec_step) && issue) begin
      pend_addr <= scan_addr;
    end
    if (cmd.scan_step && pend) begin
      if (pend_addr == head) begin
        best_entry <= rd_entry;
        head_entry <= rd_entry;
        best_idx   <= head;
      end else if (best_hit) begin
        best_entry <= rd_entry;
        best_idx   <= pend_addr;
      end
    end
    if (cmd.add_write && !full) begin
      done_q <= 1'b1;
    end
    if (cmd.retire && (best_entry.countdown <= 16'sd0)) begin
      done_q <= 1'b1;
      disp_q <= best_entry.id;
    end
    if (cmd.load_out) begin
      out_data.done_res      <= done_q;
      out_data.dispatched_id <= disp_q;
      out_data.queued        <= count[2:0];
    end
  end

  `EDFRS_ASSERT_NEXT(a_full_add_keeps_tail, clk, rst, cmd.add_write && full, $stable(tail), "add on a full ring moved the tail")
  `EDFRS_ASSERT_IMPL(a_dec_ports_apart, clk, rst, cmd.dec_step && pend, pend_addr != scan_addr, "countdown write and read hit the same slot")
  `EDFRS_ASSERT_NEXT(a_retire_dispatch, clk, rst, cmd.retire && (best_entry.countdown <= 16'sd0), done_q && (head != $past(head)), "expired head was not dispatched")

endmodule

`default_nettype wire

[src/edf_ring_scheduler_core.sv]
// channel   signals                          payload type         moves
// --------  -------------------------------  -------------------  --------------------------
// request   in_valid / in_ready / in_data    edfrs_pkg::in_t      add task or one time tick
// result    out_valid / out_ready / out_data edfrs_pkg::out_t     status, dispatched id, count
//
// one request at a time
// a tick over the queued tasks makes one entry-ram read per cycle
//   for the minimum search, up to two swap writes, then a read-modify-write pass
//   over the remaining tasks to count their deadlines down
// the result sits in an output register, so the next request is taken while it waits
// rst is synchronous and clears the ring pointers and the handshake state only
`default_nettype none

module edf_ring_scheduler_core #(
  parameter int RING_SLOTS = 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire edfrs_pkg::in_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output edfrs_pkg::out_t      out_data
);

  // command and status between the sequencer and the ring datapath
  edfrs_pkg::ctrl_cmd_t  cmd;
  edfrs_pkg::ctrl_stat_t stat;

  // sequencer: accept, add write or scan, swap, retire, countdown pass, post result
  edfrs_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .stat    (stat),
    .in_ready(in_ready),
    .cmd     (cmd)
  );

  // ring pointers, entry ram, best-entry tracking and the result register
  edfrs_datapath #(
    .RING_SLOTS(RING_SLOTS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .out_ready(out_ready),
    .stat     (stat),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int RING          = 8;
  localparam int RANDOM_REQS   = 1630;
  localparam int HOLD_EVERY    = 250;    // spacing of full drains in the random part
  localparam int DRAIN_CYCLES  = 40;
  localparam int IDLE_LIMIT    = 5000;   // cycles with no handshake before giving up
  localparam int PRINT_LIMIT   = 40;

  // receiver stall patterns
  typedef enum int {
    RX_ALWAYS,
    RX_OFTEN,
    RX_RARE
  } rx_mode_t;

  // one request waiting to be driven, optionally held until all results are back
  typedef struct {
    edfrs_pkg::in_t data;
    bit             hold;
  } pending_req_t;

  // one ring slot of the shadow scheduler
  typedef struct {
    logic [7:0]         id;
    logic signed [15:0] cd;
    logic [7:0]         rank;
  } task_slot_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic            in_valid  = 1'b0;
  logic            in_ready;
  edfrs_pkg::in_t  in_data   = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  edfrs_pkg::out_t out_data;

  pending_req_t    req_q[$];
  edfrs_pkg::out_t want_q[$];

  // shadow copy of the task ring
  task_slot_t   ring_slot[RING];
  int           head_idx = 0;
  int           tail_idx = 0;

  int           pending_results = 0;
  int           idle_cycles     = 0;
  int           fail_count      = 0;

  // driver burst / gap bookkeeping
  int           burst_left = 0;
  int           gap_left   = 0;

  // receiver stall bookkeeping
  rx_mode_t     rx_mode      = RX_ALWAYS;
  int           rx_mode_left = 0;

  edfrs_pkg::out_t want;

  always #2 clk = ~clk;

  edf_ring_scheduler_core #(
    .RING_SLOTS(RING)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // apply one request to the shadow ring and return the status it should produce
  function automatic edfrs_pkg::out_t schedule_step(input edfrs_pkg::in_t req);
    edfrs_pkg::out_t res;
    int              best;
    int              j;
    task_slot_t      tmp;
    res = '0;
    if (req.kind == edfrs_pkg::KIND_ADD) begin
      // one slot always stays empty, so a full ring drops the add
      if ((tail_idx + 1) % RING != head_idx) begin
        ring_slot[tail_idx].id   = req.task_id;
        ring_slot[tail_idx].cd   = {1'b0, req.deadline};
        ring_slot[tail_idx].rank = req.priority_req;
        tail_idx = (tail_idx + 1) % RING;
        res.done_res = 1'b1;
      end
    end else if (head_idx != tail_idx) begin
      // earliest countdown wins; on a tie a later slot needs a strictly higher rank
      best = head_idx;
      for (j = (head_idx + 1) % RING; j != tail_idx; j = (j + 1) % RING) begin
        if (ring_slot[j].cd < ring_slot[best].cd ||
            (ring_slot[j].cd == ring_slot[best].cd &&
             ring_slot[j].rank > ring_slot[best].rank))
          best = j;
      end
      tmp = ring_slot[best];
      ring_slot[best] = ring_slot[head_idx];
      ring_slot[head_idx] = tmp;
      // expired head leaves the ring
      if (ring_slot[head_idx].cd <= 0) begin
        res.done_res      = 1'b1;
        res.dispatched_id = ring_slot[head_idx].id;
        head_idx = (head_idx + 1) % RING;
      end
      // time moves on for everything still queued, floor at the most negative value
      for (j = head_idx; j != tail_idx; j = (j + 1) % RING) begin
        if (ring_slot[j].cd != edfrs_pkg::CD_MIN)
          ring_slot[j].cd = ring_slot[j].cd - 16'sd1;
      end
    end
    res.queued = 3'((tail_idx + RING - head_idx) % RING);
    return res;
  endfunction

  function automatic edfrs_pkg::in_t make_req(input logic kind, input logic [7:0] id,
                                              input logic [14:0] dl,
                                              input logic [7:0] rank);
    edfrs_pkg::in_t r;
    r.kind         = kind;
    r.task_id      = id;
    r.deadline     = dl;
    r.priority_req = rank;
    return r;
  endfunction

  task automatic push_req(input edfrs_pkg::in_t r, input bit hold);
    pending_req_t p;
    p.data = r;
    p.hold = hold;
    req_q.push_back(p);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
    if (fail_count < PRINT_LIMIT)
      $display("[%0t] mismatch on %s: got %0h, wanted %0h", $realtime, what, got_v, want_v);
    fail_count++;
  endtask

  // request driver: bursts of random length with random gaps in between
  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_valid || in_ready) begin
      // the request on the bus (if any) goes at this edge, pick the next one
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (req_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (req_q[0].hold && (in_valid || pending_results != 0)) begin
        // pause until every outstanding result has been delivered
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_data  <= req_q[0].data;
        req_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // result receiver: switches between always ready, light and heavy stalling
  always @(posedge clk) begin
    if (rst) begin
      out_ready    <= 1'b0;
      rx_mode      <= RX_ALWAYS;
      rx_mode_left <= 0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= rx_mode_t'($urandom_range(0, 2));
        rx_mode_left <= $urandom_range(20, 300);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_OFTEN:  out_ready <= ($urandom_range(0, 3) != 0);
        default:   out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // monitor: predicts on every accepted request, checks every accepted result
  always @(posedge clk) begin
    if (rst) begin
      pending_results <= 0;
      idle_cycles     <= 0;
    end else begin
      if (in_valid && in_ready)
        want_q.push_back(schedule_step(in_data));
      if (out_valid && out_ready) begin
        if (want_q.size() == 0) begin
          report_mismatch("result with no request behind it", out_data, 0);
        end else begin
          want = want_q.pop_front();
          if (out_data.done_res !== want.done_res)
            report_mismatch("done_res", out_data.done_res, want.done_res);
          if (out_data.dispatched_id !== want.dispatched_id)
            report_mismatch("dispatched_id", out_data.dispatched_id, want.dispatched_id);
          if (out_data.queued !== want.queued)
            report_mismatch("queued", out_data.queued, want.queued);
        end
      end
      pending_results <= want_q.size();
      idle_cycles <= ((in_valid && in_ready) || (out_valid && out_ready)) ?
                     0 : idle_cycles + 1;
    end
  end

  // watchdog: no handshake for too long means the block is stuck
  initial begin
    while (idle_cycles < IDLE_LIMIT)
      @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  initial begin
    bit          filling;
    int          phase_left;
    int          pick;
    logic [14:0] dl;
    logic [7:0]  rank;

    // directed part
    // tick on an empty ring: nothing dispatched, nothing changes
    push_req(make_req(edfrs_pkg::KIND_TICK, 8'h00, 15'h0000, 8'h00), 1'b0);
    // task with the longest deadline, top id and top rank: stays parked all run
    push_req(make_req(edfrs_pkg::KIND_ADD, 8'hff, 15'h7fff, 8'hff), 1'b0);
    // tick with no expired task: countdowns still move, ignored fields all ones
    push_req(make_req(edfrs_pkg::KIND_TICK, 8'hff, 15'h7fff, 8'hff), 1'b0);
    // three expired tasks tied on countdown: higher rank later in ring wins,
    // equal rank later in ring loses
    push_req(make_req(edfrs_pkg::KIND_ADD, 8'h00, 15'h0000, 8'h00), 1'b0);
    push_req(make_req(edfrs_pkg::KIND_ADD, 8'h11, 15'h0000, 8'd200), 1'b0);
    push_req(make_req(edfrs_pkg::KIND_ADD, 8'h22, 15'h0000, 8'd200), 1'b0);
    push_req(make_req(edfrs_pkg::KIND_TICK, 8'h00, 15'h0000, 8'h00), 1'b0);
    // fill the ring to seven tasks, then one add too many
    push_req(make_req(edfrs_pkg::KIND_ADD, 8'h33, 15'd1, 8'd5), 1'b0);
    push_req(make_req(edfrs_pkg::KIND_ADD, 8'h44, 15'd1, 8'd9), 1'b0);
    push_req(make_req(edfrs_pkg::KIND_ADD, 8'h55, 15'd2, 8'd0), 1'b0);
    push_req(make_req(edfrs_pkg::KIND_ADD, 8'h66, 15'd3, 8'hff), 1'b0);
    push_req(make_req(edfrs_pkg::KIND_ADD, 8'h77, 15'd0, 8'd1), 1'b0);
    // drain down to the parked task, the last tick dispatches nothing
    repeat (7)
      push_req(make_req(edfrs_pkg::KIND_TICK, 8'($urandom), 15'($urandom), 8'($urandom)),
               1'b0);

    // random part: alternate fill-heavy and drain-heavy stretches so the ring
    // keeps swinging between full and only the parked task; short deadlines and narrow ranks for ties
    filling    = 1'b1;
    phase_left = 0;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (phase_left == 0) begin
        filling    = !filling;
        phase_left = $urandom_range(4, 30);
      end
      phase_left--;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        // noise: tick carrying random junk in the ignored fields
        push_req(make_req(edfrs_pkg::KIND_TICK, 8'($urandom), 15'($urandom),
                          8'($urandom)), (n % HOLD_EVERY) == 0);
      end else if (pick < (filling ? 72 : 28)) begin
        pick = $urandom_range(0, 99);
        if (pick < 60)
          dl = 15'($urandom_range(0, 4));
        else if (pick < 90)
          dl = 15'($urandom_range(5, 40));
        else
          dl = 15'($urandom_range(41, 300));
        rank = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        push_req(make_req(edfrs_pkg::KIND_ADD, 8'($urandom), dl, rank),
                 (n % HOLD_EVERY) == 0);
      end else begin
        push_req(make_req(edfrs_pkg::KIND_TICK, 8'($urandom), 15'($urandom_range(0, 40)),
                          8'($urandom)), (n % HOLD_EVERY) == 0);
      end
    end

    // single reset at the start
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // wait for all requests to go out and every result to come back
    do
      @(negedge clk);
    while (req_q.size() != 0 || in_valid || pending_results != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (want_q.size() != 0)
      report_mismatch("results never delivered", want_q.size(), 0);

    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
